// ===== rtl/six_slot_line_sum_check_repair_unit_macros.svh =====
// assertion macros for the line sum check and repair unit
`ifndef SIX_SLOT_LINE_SUM_CHECK_REPAIR_UNIT_MACROS_SVH
`define SIX_SLOT_LINE_SUM_CHECK_REPAIR_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define SSLS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication checked outside reset
`define SSLS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/ssls_pkg.sv =====
// ----------------------------------------------------------------------------
// ssls_pkg
// shared types and constants of the six slot line sum check and repair unit
// ----------------------------------------------------------------------------
package ssls_pkg;
	localparam int SLOTS = 6;
	localparam int VW    = 64;
	localparam int SUMW  = 66;
	localparam int IDXW  = 3;
	localparam int CW    = 7;

	typedef logic [IDXW-1:0] idx_t;
	typedef idx_t [SLOTS-1:0] perm_t;

	typedef enum logic [1:0] {
		ST_CONSISTENT = 2'd0,
		ST_REPAIRED   = 2'd1,
		ST_MISMATCH   = 2'd2
	} status_t;

	// request and status between sequencer and modulo unit
	typedef struct packed {
		logic start;
	} mod_req_t;
	typedef struct packed {
		logic busy;
		logic done;
	} mod_stat_t;
endpackage

// ===== rtl/ssls_mod3.sv =====
// ----------------------------------------------------------------------------
// ssls_mod3
// bit-serial restoring reduction of three line sums by one modulus
// ----------------------------------------------------------------------------
module ssls_mod3 (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ssls_pkg::mod_req_t    req,
	input  logic [63:0]           a,
	input  logic [63:0]           b,
	input  logic [63:0]           c,
	input  logic [63:0]           m,
	output ssls_pkg::mod_stat_t   stat,
	output logic                  agree
);
	import ssls_pkg::*;

	logic [63:0] sa_q, sb_q, sc_q;
	logic [64:0] ra_q, rb_q, rc_q;
	logic [6:0]  cnt_q;
	logic        busy_q, done_q;
	logic [64:0] na, nb, nc;

	// one dividend bit shifted into each remainder per cycle
	always_comb begin
		na = {ra_q[63:0], sa_q[63]};
		nb = {rb_q[63:0], sb_q[63]};
		nc = {rc_q[63:0], sc_q[63]};
		if (na >= {1'b0, m}) na = na - {1'b0, m};
		if (nb >= {1'b0, m}) nb = nb - {1'b0, m};
		if (nc >= {1'b0, m}) nc = nc - {1'b0, m};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath shift registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			sa_q <= a; sb_q <= b; sc_q <= c;
			ra_q <= '0; rb_q <= '0; rc_q <= '0;
		end else if (busy_q) begin
			sa_q <= sa_q << 1; sb_q <= sb_q << 1; sc_q <= sc_q << 1;
			ra_q <= na; rb_q <= nb; rc_q <= nc;
		end
	end

	assign stat  = '{busy: busy_q, done: done_q};
	assign agree = (ra_q == rb_q) && (rb_q == rc_q);
endmodule

// ===== rtl/six_slot_line_sum_check_repair_unit.sv =====
// ----------------------------------------------------------------------------
// six_slot_line_sum_check_repair_unit
// checks three line sums of six slots and searches a repairing permutation
// ----------------------------------------------------------------------------
// channel   dir  payload
// s_axis    in   six 64-bit values
// m_axis    out  status and six source indices
// cfg       in   64-bit modulus
//
// each permutation is launched in S_RUN, reduced bit-serially in S_WAIT until
// done and compared in S_NEXT; an item tries up to 720 orders and stops at
// the first one that agrees. reset loads modulus 1.
// one item at a time; the next is taken once the result register is free.
module six_slot_line_sum_check_repair_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [383:0] s_axis_tdata,   // value_0 .. value_5, 64 bits each
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [23:0]  m_axis_tdata,   // status(2), source_0..source_5(3 each), pad
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [63:0]  cfg_data
);
	import ssls_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RUN  = 4'b0010,
		S_WAIT = 4'b0100,
		S_NEXT = 4'b1000
	} state_t;

	state_t        state_q;
	logic [63:0]   mod_q;
	logic [63:0]   v_q [SLOTS];
	perm_t         p_q;
	logic          first_q;
	logic          ovalid_q;
	logic [23:0]   odata_q;
	mod_req_t      req;
	mod_stat_t     stat;
	logic          agree;
	logic [63:0]   q [SLOTS];
	logic [63:0]   sa, sb, sc, meff;
	perm_t         pn;
	logic          pn_ok;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;
	assign meff          = (mod_q == 64'd0) ? 64'd1 : mod_q;

	// reordered group and its line sums
	always_comb begin
		for (int k = 0; k < SLOTS; k++) q[k] = v_q[p_q[k]];
		sa = q[0] + q[1] + q[2];
		sb = q[2] + q[3] + q[4];
		sc = q[4] + q[5] + q[0];
	end

	// next permutation in lexicographic order
	always_comb begin
		logic [2:0] i, j;
		logic fi, fj;
		perm_t sw;
		i = '0; j = '0; fi = 1'b0; fj = 1'b0;
		for (int k = SLOTS - 2; k >= 0; k--)
			if (!fi && p_q[k] < p_q[k+1]) begin i = 3'(k); fi = 1'b1; end
		for (int k = SLOTS - 1; k >= 0; k--)
			if (fi && !fj && p_q[k] > p_q[i]) begin j = 3'(k); fj = 1'b1; end
		// swap the pivot, then reverse the tail behind it
		sw = p_q;
		sw[i] = p_q[j];
		sw[j] = p_q[i];
		pn = p_q;
		if (fi) begin
			pn = sw;
			for (int k = 1; k < SLOTS; k++)
				if (3'(k) > i) pn[k] = sw[3'(SLOTS + 32'(i) - k)];
		end
		pn_ok = fi;
	end

	assign req.start = (state_q == S_RUN);

	ssls_mod3 u_mod (
		.clk(clk), .arst_n(arst_n), .req(req),
		.a(sa), .b(sb), .c(sc), .m(meff),
		.stat(stat), .agree(agree)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mod_q    <= 64'd1;
			ovalid_q <= 1'b0;
			first_q  <= 1'b0;
		end else begin
			if (cfg_valid) mod_q <= cfg_data;
			if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					state_q <= S_RUN;
					first_q <= 1'b1;
				end
				S_RUN:  state_q <= S_WAIT;
				S_WAIT: if (stat.done) state_q <= S_NEXT;
				S_NEXT: begin
					first_q <= 1'b0;
					if (agree || !pn_ok) begin
						ovalid_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_RUN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// group, order and result payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_axis_tvalid && s_axis_tready) begin
			for (int k = 0; k < SLOTS; k++) begin
				v_q[k] <= s_axis_tdata[k*VW +: VW];
				p_q[k] <= idx_t'(k);
			end
		end else if (state_q == S_NEXT) begin
			if (agree) begin
				odata_q <= {4'd0, p_q[5], p_q[4], p_q[3], p_q[2], p_q[1], p_q[0],
					first_q ? ST_CONSISTENT : ST_REPAIRED};
			end else if (!pn_ok) begin
				odata_q <= {4'd0, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0, ST_MISMATCH};
			end else begin
				p_q <= pn;
			end
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = odata_q;
endmodule

// ===== rtl/ssls_checker.sv =====
// ----------------------------------------------------------------------------
// ssls_checker
// port-level checks of the line sum check and repair unit
// ----------------------------------------------------------------------------
`include "six_slot_line_sum_check_repair_unit_macros.svh"
module ssls_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [23:0]  m_axis_tdata
);
	`SSLS_ASSERT_IMP(a_status_legal, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3)
	`SSLS_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`SSLS_ASSERT_IMP(a_no_take_while_full, m_axis_tvalid, !s_axis_tready)
	`SSLS_ASSERT_NXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

bind six_slot_line_sum_check_repair_unit ssls_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
